// File: hdl/dhs_pkg.sv
// Shared types and constants for the double-hashing set core.
// No dependencies; dhs_front, dhs_back and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package dhs_pkg;

  localparam int unsigned KEY_W     = 28;
  localparam int unsigned LIMIT_W   = 21;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned LETTERS_W = 24;

  localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RST = 21'd1048576;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_FIND   = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    F_IDLE,
    F_GROUP,
    F_TOTAL,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CHECK
  } back_state_e;

  typedef struct packed {
    logic present;
    logic stored;
    logic overflow;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/dhs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic             we_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/dhs_queue.sv
// Small register FIFO between the front and back parts.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dhs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dhs_front.sv
// Front part: takes an item, forms the base-5 key and both residues.
// Depends on dhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhs_front #(
  parameter int unsigned TABLE_SIZE  = 1048576,
  parameter int unsigned MAX_LETTERS = 12,
  localparam int unsigned AW         = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic                            mode_i,
  input  wire logic [dhs_pkg::LEN_W-1:0]       word_length_i,
  input  wire logic [dhs_pkg::LETTERS_W-1:0]   letters_i,
  output logic                                 busy_o,
  output logic                                 job_valid_o,
  input  wire logic                            job_ready_i,
  output logic                                 job_mode_o,
  output logic      [dhs_pkg::KEY_W-1:0]       job_key_o,
  output logic      [AW-1:0]                   job_slot_o,
  output logic      [AW-1:0]                   job_stride_o
);

  localparam int unsigned KW        = dhs_pkg::KEY_W;
  localparam int unsigned MW        = KW + 1;
  localparam int unsigned PW        = KW + MW;
  localparam int unsigned SW        = 2;
  localparam int unsigned MOD_STEPS = 3;
  localparam int unsigned NGRP      = 3;
  localparam int unsigned GRP       = 4;
  localparam int unsigned DIV_A     = TABLE_SIZE;
  localparam int unsigned DIV_B     = TABLE_SIZE - 1;
  localparam int unsigned SH_A      = KW + $clog2(DIV_A);
  localparam int unsigned SH_B      = KW + $clog2(DIV_B);
  localparam logic [MW-1:0] RECIP_A = MW'((64'd1 << SH_A) / 64'(DIV_A));
  localparam logic [MW-1:0] RECIP_B = MW'((64'd1 << SH_B) / 64'(DIV_B));
  localparam logic [dhs_pkg::LEN_W-1:0] LEN_MAX = dhs_pkg::LEN_W'(MAX_LETTERS);

  function automatic logic [KW-1:0] pow5(input int unsigned j);
    logic [KW-1:0] w;
    w = KW'(1);
    for (int unsigned i = 0; i < j; i++) begin
      w = w * KW'(5);
    end
    return w;
  endfunction

  dhs_pkg::front_state_e state_q, state_d;
  logic [SW-1:0]         step_q, step_d;

  logic                             mode_q;
  logic [dhs_pkg::LEN_W-1:0]        len_q, len_sat;
  logic [dhs_pkg::LETTERS_W-1:0]    letters_q;
  logic [KW-1:0]                    grp_q [NGRP];
  logic [KW-1:0]                    grp_sum [NGRP];
  logic [KW-1:0]                    key_q, key_sum;
  logic [PW-1:0]                    prod_a, prod_b;
  logic [KW-1:0]                    quo_a, quo_b, q_a_q, q_b_q;
  logic [KW-1:0]                    rem_a_q, rem_b_q, rem_a_est, rem_b_est;
  logic [KW-1:0]                    rem_a_fix, rem_b_fix;

  always_comb begin
    if (word_length_i == '0) begin
      len_sat = dhs_pkg::LEN_W'(1);
    end else if (word_length_i > LEN_MAX) begin
      len_sat = LEN_MAX;
    end else begin
      len_sat = word_length_i;
    end
  end

  // Letter j weighs (code + 1) * 5^j; letters past the word length count nothing.
  always_comb begin
    int unsigned j;
    logic [1:0]  code;
    for (int unsigned g = 0; g < NGRP; g++) begin
      grp_sum[g] = '0;
      for (int unsigned l = 0; l < GRP; l++) begin
        j    = g * GRP + l;
        code = letters_q[2*j +: 2];
        if (dhs_pkg::LEN_W'(j) < len_q) begin
          grp_sum[g] = grp_sum[g] + pow5(j) * KW'(code) + pow5(j);
        end
      end
    end
  end

  assign key_sum = grp_q[0] + grp_q[1] + grp_q[2];

  // The reciprocal quotient falls short by at most one, so one
  // compare-and-subtract finishes each residue.
  assign prod_a    = {{MW{1'b0}}, key_q} * {{KW{1'b0}}, RECIP_A};
  assign prod_b    = {{MW{1'b0}}, key_q} * {{KW{1'b0}}, RECIP_B};
  assign quo_a     = KW'(prod_a >> SH_A);
  assign quo_b     = KW'(prod_b >> SH_B);
  assign rem_a_est = key_q - q_a_q * KW'(DIV_A);
  assign rem_b_est = key_q - q_b_q * KW'(DIV_B);
  assign rem_a_fix = (rem_a_q >= KW'(DIV_A)) ? rem_a_q - KW'(DIV_A) : rem_a_q;
  assign rem_b_fix = (rem_b_q >= KW'(DIV_B)) ? rem_b_q - KW'(DIV_B) : rem_b_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      dhs_pkg::F_IDLE: begin
        if (accept_i) begin
          state_d = dhs_pkg::F_GROUP;
        end
      end
      dhs_pkg::F_GROUP: begin
        state_d = dhs_pkg::F_TOTAL;
      end
      dhs_pkg::F_TOTAL: begin
        state_d = dhs_pkg::F_MOD;
        step_d  = '0;
      end
      dhs_pkg::F_MOD: begin
        step_d = step_q + SW'(1);
        if (step_q == SW'(MOD_STEPS - 1)) begin
          state_d = dhs_pkg::F_PUSH;
        end
      end
      dhs_pkg::F_PUSH: begin
        if (job_ready_i) begin
          state_d = dhs_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = dhs_pkg::F_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o      = 1'b1;
    job_valid_o = 1'b0;
    unique case (state_q)
      dhs_pkg::F_IDLE: busy_o      = 1'b0;
      dhs_pkg::F_PUSH: job_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dhs_pkg::F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dhs_pkg::F_IDLE: begin
        if (accept_i) begin
          mode_q    <= mode_i;
          len_q     <= len_sat;
          letters_q <= letters_i;
        end
      end
      dhs_pkg::F_GROUP: begin
        for (int unsigned g = 0; g < NGRP; g++) begin
          grp_q[g] <= grp_sum[g];
        end
      end
      dhs_pkg::F_TOTAL: begin
        key_q <= key_sum;
      end
      dhs_pkg::F_MOD: begin
        if (step_q == '0) begin
          q_a_q <= quo_a;
          q_b_q <= quo_b;
        end else if (step_q == SW'(1)) begin
          rem_a_q <= rem_a_est;
          rem_b_q <= rem_b_est;
        end else begin
          rem_a_q <= rem_a_fix;
          rem_b_q <= rem_b_fix;
        end
      end
      default: ;
    endcase
  end

  assign job_mode_o   = mode_q;
  assign job_key_o    = key_q;
  assign job_slot_o   = rem_a_q[AW-1:0];
  assign job_stride_o = rem_b_q[AW-1:0] + AW'(1);

endmodule

`default_nettype wire

// File: hdl/dhs_back.sv
// Back part: clears the table after reset, then probes it for each job.
// Depends on dhs_pkg and dhs_ram.
`timescale 1ns / 1ps
`default_nettype none

module dhs_back #(
  parameter int unsigned TABLE_SIZE = 1048576,
  localparam int unsigned AW        = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1,
  localparam int unsigned JW        = 1 + dhs_pkg::KEY_W + 2 * AW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          job_valid_i,
  input  wire logic [JW-1:0]                 job_i,
  output logic                               job_pop_o,
  input  wire logic [dhs_pkg::LIMIT_W-1:0]   probe_limit_i,
  output logic                               clearing_o,
  output logic                               done_o,
  output dhs_pkg::result_t                   result_o
);

  localparam int unsigned KW = dhs_pkg::KEY_W;
  localparam int unsigned LW = dhs_pkg::LIMIT_W;

  dhs_pkg::back_state_e state_q, state_d;
  logic [AW-1:0]        clr_q;
  logic                 done_q;
  dhs_pkg::result_t     res_q;

  logic          mode_q;
  logic [KW-1:0] key_q;
  logic [AW-1:0] slot_q, stride_q, next_slot;
  logic [LW-1:0] cnt_q, cnt_inc, eff_limit;
  logic [AW:0]   slot_sum;

  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [KW-1:0] mem_wdata, mem_rdata;

  logic hit, empty, last, finish, do_store;

  dhs_ram #(
    .WIDTH(KW),
    .DEPTH(TABLE_SIZE)
  ) u_table (
    .clk_i  (clk_i),
    .addr_i (mem_addr),
    .we_i   (mem_we),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign eff_limit = (probe_limit_i == '0) ? LW'(1) : probe_limit_i;
  assign cnt_inc   = cnt_q + LW'(1);
  assign hit       = (mem_rdata == key_q);
  assign empty     = (mem_rdata == '0);
  assign last      = (cnt_inc == eff_limit);
  assign finish    = hit || empty || last;
  assign do_store  = !hit && empty && (mode_q == dhs_pkg::MODE_INSERT);

  // Both terms are below the table size, so one subtract wraps the sum.
  assign slot_sum  = {1'b0, slot_q} + {1'b0, stride_q};
  assign next_slot = (slot_sum >= (AW + 1)'(TABLE_SIZE))
                   ? AW'(slot_sum - (AW + 1)'(TABLE_SIZE)) : slot_sum[AW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhs_pkg::B_CLEAR: begin
        if (clr_q == AW'(TABLE_SIZE - 1)) begin
          state_d = dhs_pkg::B_IDLE;
        end
      end
      dhs_pkg::B_IDLE: begin
        if (job_valid_i) begin
          state_d = dhs_pkg::B_READ;
        end
      end
      dhs_pkg::B_READ: begin
        state_d = dhs_pkg::B_CHECK;
      end
      dhs_pkg::B_CHECK: begin
        state_d = finish ? dhs_pkg::B_IDLE : dhs_pkg::B_READ;
      end
      default: begin
        state_d = dhs_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_addr   = slot_q;
    mem_we     = 1'b0;
    mem_wdata  = key_q;
    job_pop_o  = 1'b0;
    clearing_o = 1'b0;
    unique case (state_q)
      dhs_pkg::B_CLEAR: begin
        mem_addr   = clr_q;
        mem_we     = 1'b1;
        mem_wdata  = '0;
        clearing_o = 1'b1;
      end
      dhs_pkg::B_IDLE: begin
        job_pop_o = job_valid_i;
      end
      dhs_pkg::B_CHECK: begin
        mem_we = do_store;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dhs_pkg::B_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == dhs_pkg::B_CHECK) && finish;
      if (state_q == dhs_pkg::B_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dhs_pkg::B_IDLE && job_valid_i) begin
      mode_q   <= job_i[JW-1];
      key_q    <= job_i[JW-2 -: KW];
      slot_q   <= job_i[2*AW-1 -: AW];
      stride_q <= job_i[AW-1:0];
      cnt_q    <= '0;
    end else if (state_q == dhs_pkg::B_CHECK && !finish) begin
      slot_q <= next_slot;
      cnt_q  <= cnt_inc;
    end
    if (state_q == dhs_pkg::B_CHECK) begin
      res_q.present  <= hit;
      res_q.stored   <= do_store;
      res_q.overflow <= !hit && !empty && last;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// File: hdl/double_hash_set_insert_find_core.sv
// Top level of the double-hashing DNA word set: front, queue, back.
// Depends on dhs_pkg, dhs_front, dhs_queue, dhs_back and dhs_ram.
//
// Usage
//   Raise start with mode_i (0 insert, 1 find), word_length_i and letters_i;
//   the item is taken at a clock edge where start is high and busy is low.
//   Each item gives one result: done_o is high for exactly one cycle with
//   present_o, stored_o and overflow_o. The receiver cannot hold results off.
//   cfg_we_i with cfg_wdata_i writes probe_limit; write it only while idle.
// Flow
//   The front part registers the item, forms the key as group sums and then
//   a total, reduces it by both moduli with a reciprocal multiplication, a
//   remainder estimate and a correction, then hands the job to the queue,
//   waiting while the queue is full. A two-entry queue feeds the back part,
//   which picks up the job in its idle state and then makes each table probe
//   in a read state and a check state on the single RAM port. The front part
//   can take a new item while the back part is still probing earlier jobs.
// Reset
//   After reset the table is cleared one slot per cycle, over all TABLE_SIZE slots,
//   with busy held high; probe_limit resets to 1048576 and may be written.
`timescale 1ns / 1ps
`default_nettype none

module double_hash_set_insert_find_core #(
  parameter int unsigned TABLE_SIZE  = 1048576,
  parameter int unsigned MAX_LETTERS = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             cfg_we_i,
  input  wire logic [dhs_pkg::LIMIT_W-1:0]      cfg_wdata_i,
  input  wire logic                             mode_i,
  input  wire logic [dhs_pkg::LEN_W-1:0]        word_length_i,
  input  wire logic [dhs_pkg::LETTERS_W-1:0]    letters_i,
  output logic                                  done_o,
  output logic                                  present_o,
  output logic                                  stored_o,
  output logic                                  overflow_o
);

  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned JW = 1 + dhs_pkg::KEY_W + 2 * AW;

  logic [dhs_pkg::LIMIT_W-1:0] probe_limit_q;

  logic                        accept;
  logic                        front_busy;
  logic                        clearing;
  logic                        job_valid, q_full, q_valid, q_pop;
  logic                        job_mode;
  logic [dhs_pkg::KEY_W-1:0]   job_key;
  logic [AW-1:0]               job_slot, job_stride;
  logic [JW-1:0]               q_head;
  dhs_pkg::result_t            result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_limit_q <= dhs_pkg::PROBE_LIMIT_RST;
    end else if (cfg_we_i) begin
      probe_limit_q <= cfg_wdata_i;
    end
  end

  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  dhs_front #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_LETTERS(MAX_LETTERS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .word_length_i(word_length_i),
    .letters_i    (letters_i),
    .busy_o       (front_busy),
    .job_valid_o  (job_valid),
    .job_ready_i  (!q_full),
    .job_mode_o   (job_mode),
    .job_key_o    (job_key),
    .job_slot_o   (job_slot),
    .job_stride_o (job_stride)
  );

  dhs_queue #(
    .WIDTH(JW),
    .DEPTH(dhs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_valid),
    .data_i ({job_mode, job_key, job_slot, job_stride}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_head)
  );

  dhs_back #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (q_head),
    .job_pop_o    (q_pop),
    .probe_limit_i(probe_limit_q),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .result_o     (result)
  );

  assign present_o  = result.present;
  assign stored_o   = result.stored;
  assign overflow_o = result.overflow;

  // At most one outcome flag per result; a find that reaches an empty slot has none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({present_o, stored_o, overflow_o}))
    else $error("more than one outcome flag on a result");

  // A transfer in always occupies the front part on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("front part free right after a transfer");

  // No result can come out, and busy stays high, while the table is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!done_o && busy))
    else $error("result or transfer possible during table clear");

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for double_hash_set_insert_find_core: directed, collision-chain and
// random insert/find traffic, each result checked against an in-bench model of the set.
// Depends on dhs_pkg and the core RTL; reads no files.

module tb;
  import dhs_pkg::*;

  localparam int unsigned TABLE_SIZE   = 1048576;
  localparam int unsigned MAX_LETTERS  = 12;
  localparam int unsigned MAX_KEY      = 244140624;  // twelve letters T
  localparam int unsigned KEY_SPAN     = MAX_KEY / TABLE_SIZE + 1;
  localparam int          STALL_LIMIT  = 3000000;    // covers the clearing pass after reset
  localparam int          RANDOM_ITEMS = 600;
  localparam int          N_PHASES     = 7;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 start         = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wdata_i   = '0;
  logic                 mode_i        = MODE_INSERT;
  logic [LEN_W-1:0]     word_length_i = '0;
  logic [LETTERS_W-1:0] letters_i     = '0;
  wire                  busy;
  wire                  done_o;
  wire                  present_o;
  wire                  stored_o;
  wire                  overflow_o;

  logic [LIMIT_W-1:0] probe_limit_q = PROBE_LIMIT_RST;
  logic [KEY_W-1:0]   table_keys [int unsigned];
  int unsigned        known_keys [$];
  result_t            pending_results [$];
  int                 mismatch_count = 0;
  int                 stall_cycles   = 0;
  int                 items_sent     = 0;
  int                 gap_pct        = 0;

  double_hash_set_insert_find_core #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_LETTERS(MAX_LETTERS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (mode_i),
    .word_length_i(word_length_i),
    .letters_i    (letters_i),
    .done_o       (done_o),
    .present_o    (present_o),
    .stored_o     (stored_o),
    .overflow_o   (overflow_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned word_key(logic [LEN_W-1:0] len, logic [LETTERS_W-1:0] lt);
    int unsigned n;
    int unsigned key;
    int unsigned weight;
    n = len;
    if (n < 1) n = 1;
    if (n > MAX_LETTERS) n = MAX_LETTERS;
    key = 0;
    weight = 1;
    for (int j = 0; j < n; j++) begin
      key += (int'(lt[2*j +: 2]) + 1) * weight;
      weight *= 5;
    end
    return key;
  endfunction

  function automatic int unsigned probe_slot(int unsigned key, int unsigned i);
    longint unsigned s;
    s = longint'(key % TABLE_SIZE) + longint'(i) * longint'(1 + key % (TABLE_SIZE - 1));
    return int'(s % TABLE_SIZE);
  endfunction

  // Probe the modelled table and update it exactly as the core should.
  function automatic result_t apply_to_set(logic m, logic [LEN_W-1:0] len,
                                           logic [LETTERS_W-1:0] lt);
    int unsigned key;
    int unsigned slot;
    int unsigned stride;
    int unsigned limit;
    int unsigned held;
    result_t     r;
    r = '0;
    key = word_key(len, lt);
    slot = key % TABLE_SIZE;
    stride = 1 + key % (TABLE_SIZE - 1);
    limit = (probe_limit_q == '0) ? 1 : int'(probe_limit_q);
    for (int unsigned i = 0; i < limit; i++) begin
      held = table_keys.exists(slot) ? table_keys[slot] : 0;
      if (held == key) begin
        r.present = 1'b1;
        return r;
      end
      if (held == 0) begin
        if (m == MODE_INSERT) begin
          table_keys[slot] = KEY_W'(key);
          known_keys.push_back(key);
          r.stored = 1'b1;
        end
        return r;
      end
      slot = (slot + stride) % TABLE_SIZE;
    end
    r.overflow = 1'b1;
    return r;
  endfunction

  // Spell a key back into letters (bijective base 5); unused letter bits are random.
  function automatic bit key_to_word(input int unsigned key, output logic [LEN_W-1:0] len,
                                     output logic [LETTERS_W-1:0] lt);
    int unsigned k;
    int unsigned d;
    int unsigned n;
    k = key;
    n = 0;
    lt = LETTERS_W'($urandom);
    len = '0;
    if (k == 0) return 1'b0;
    while (k != 0) begin
      if (n == MAX_LETTERS) return 1'b0;
      d = k % 5;
      if (d == 0) return 1'b0;
      lt[2*n +: 2] = 2'(d - 1);
      k = (k - d) / 5;
      n++;
    end
    len = LEN_W'(n);
    if (n == 1) len = LEN_W'($urandom_range(0, 1));
    if (n == MAX_LETTERS) len = LEN_W'($urandom_range(MAX_LETTERS, 15));
    return 1'b1;
  endfunction

  // Some spellable key other than avoid whose first probe lands on slot s.
  function automatic int unsigned key_at_slot(int unsigned s, int unsigned avoid);
    int unsigned          m;
    int unsigned          k;
    logic [LEN_W-1:0]     l;
    logic [LETTERS_W-1:0] t;
    m = $urandom_range(0, KEY_SPAN - 1);
    repeat (KEY_SPAN) begin
      k = s + m * TABLE_SIZE;
      if (k != avoid && k <= MAX_KEY && key_to_word(k, l, t)) return k;
      m = (m + 1) % KEY_SPAN;
    end
    return 0;
  endfunction

  function automatic int unsigned random_key();
    int unsigned          k;
    logic [LEN_W-1:0]     l;
    logic [LETTERS_W-1:0] t;
    do k = $urandom_range(1, MAX_KEY); while (!key_to_word(k, l, t));
    return k;
  endfunction

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, actual p=%b s=%b o=%b",
                 $time, present_o, stored_o, overflow_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (present_o !== want.present) begin
          $display("%0t: present expected %b actual %b", $time, want.present, present_o);
          mismatch_count++;
        end
        if (stored_o !== want.stored) begin
          $display("%0t: stored expected %b actual %b", $time, want.stored, stored_o);
          mismatch_count++;
        end
        if (overflow_o !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, want.overflow, overflow_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_item(logic m, logic [LEN_W-1:0] len, logic [LETTERS_W-1:0] lt);
    int gap;
    if ($urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    mode_i        <= m;
    word_length_i <= len;
    letters_i     <= lt;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(apply_to_set(m, len, lt));
    items_sent++;
  endtask

  task automatic send_key(logic m, int unsigned key);
    logic [LEN_W-1:0]     l;
    logic [LETTERS_W-1:0] t;
    if (key_to_word(key, l, t)) send_item(m, l, t);
  endtask

  // Drop start and hold until every pending result has been checked.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_probe_limit(logic [LIMIT_W-1:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    probe_limit_q = v;
  endtask

  // Occupy the first depth probe slots of a random word, then insert or find it; sometimes find and insert it again.
  task automatic run_chain(int depth, logic target_mode);
    int unsigned target;
    int unsigned k;
    target = random_key();
    for (int i = 0; i < depth; i++) begin
      k = key_at_slot(probe_slot(target, i), target);
      if (k != 0) send_key(MODE_INSERT, k);
    end
    send_key(target_mode, target);
    if ($urandom_range(0, 1)) begin
      send_key(MODE_FIND, target);
      send_key(MODE_INSERT, target);
    end
  endtask

  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)
      run_chain($urandom_range(0, 3), logic'($urandom_range(0, 1)));
    else if (sel < 60 && known_keys.size() != 0)
      send_key(logic'($urandom_range(0, 1)), known_keys[$urandom_range(0, known_keys.size() - 1)]);
    else
      send_item(logic'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 15)),
                LETTERS_W'($urandom));
  endtask

  task automatic test_word_forms();
    gap_pct = 50;
    send_item(MODE_FIND,   4'd1,  24'h000000);
    send_item(MODE_INSERT, 4'd0,  24'h000000);  // zero length reads as one letter
    send_item(MODE_INSERT, 4'd1,  24'hFFFFFC);  // letters above the length are ignored
    send_item(MODE_FIND,   4'd1,  24'h000003);
    send_item(MODE_INSERT, 4'd12, 24'hFFFFFF);
    send_item(MODE_FIND,   4'd15, 24'hFFFFFF);  // length saturates at twelve
    send_item(MODE_INSERT, 4'd13, 24'h000000);
    send_item(MODE_FIND,   4'd12, 24'h000000);
    send_item(MODE_INSERT, 4'd4,  24'h0000E4);
    send_item(MODE_FIND,   4'd3,  24'h0000E4);
    send_item(MODE_INSERT, 4'd4,  24'hABCDE4);  // repeated insert
    send_item(MODE_FIND,   4'd14, 24'hFFFFFF);
    send_item(MODE_FIND,   4'd11, 24'hFFFFFF);
    send_item(MODE_INSERT, 4'd11, 24'h555555);
  endtask

  task automatic test_probe_limits();
    int unsigned target;
    int unsigned rival;
    gap_pct = 30;
    target = random_key();
    rival = key_at_slot(target % TABLE_SIZE, target);
    write_probe_limit(21'd1);
    send_key(MODE_INSERT, rival);
    send_key(MODE_INSERT, target);
    send_key(MODE_FIND, target);
    send_key(MODE_FIND, rival);
    write_probe_limit(21'd0);  // zero allows a single probe
    send_key(MODE_INSERT, target);
    write_probe_limit(21'd2);
    send_key(MODE_INSERT, target);
    send_key(MODE_FIND, target);
    write_probe_limit(21'h1FFFFF);
    run_chain(3, MODE_INSERT);
  endtask

  task automatic test_random_phases();
    logic [LIMIT_W-1:0] limits [N_PHASES] = '{21'd1048576, 21'h1FFFFF, 21'd3, 21'd2,
                                               21'd1, 21'd0, 21'd1048576};
    int                 gaps   [N_PHASES] = '{30, 0, 50, 20, 40, 25, 0};
    int                 phase_end;
    for (int p = 0; p < N_PHASES; p++) begin
      write_probe_limit(limits[p]);
      gap_pct = gaps[p];
      phase_end = items_sent + RANDOM_ITEMS / N_PHASES;
      while (items_sent < phase_end) random_item();
    end
  endtask

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_word_forms();
    test_probe_limits();
    test_random_phases();
    drain_results();
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
hdl/dhs_pkg.sv
hdl/dhs_ram.sv
hdl/dhs_queue.sv
hdl/dhs_front.sv
hdl/dhs_back.sv
hdl/double_hash_set_insert_find_core.sv
bench/tb.sv
